/* rtl/core/mcl_pkg.sv */
package mcl_pkg;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD_CAT  = 2'd2,
    ST_BAD_POS  = 2'd3
  } status_t;

  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEN,
    S_SCAN,
    S_UPDATE,
    S_BUB,
    S_RD,
    S_OUT
  } state_t;

endpackage

/* rtl/core/mcl_if.sv */
interface mcl_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [3:0]  category;
  logic [31:0] user_id;
  logic [31:0] amount;
  logic [7:0]  position;
  modport source (output valid, action, category, user_id, amount, position, input ready);
  modport sink (input valid, action, category, user_id, amount, position, output ready);
endinterface

interface mcl_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] entry_user;
  logic [31:0] entry_count;
  logic [8:0]  entry_rank;
  logic [8:0]  list_length;
  modport source (output valid, status, entry_user, entry_count, entry_rank, list_length,
                  input ready);
  modport sink (input valid, status, entry_user, entry_count, entry_rank, list_length,
                output ready);
endinterface

/* rtl/core/mcl_ram.sv */
module mcl_ram #(
  parameter int DEPTH = 3072,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [63:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [63:0]   rdata
);
  logic [63:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/core/multi_category_leaderboard_core.sv */
// Channel | Direction | Fields
// in      | request   | action, category, user_id, amount, position
// out     | result    | status, entry_user, entry_count, entry_rank, list_length
// A request is taken only in the idle state, after the previous result has been taken.
// Bad categories go straight to the result; in-range reads pass the length and read states.
// An add reads the list length, scans the entries for the user, then writes the entry and
// moves it up past each entry with a smaller count; a new user on a full list gets ST_FULL.
// Reset (rst, synchronous) clears the list lengths; entry memory needs no clearing.
// The result is held until out.ready; in.ready stays low meanwhile.
module multi_category_leaderboard_core import mcl_pkg::*; #(
  parameter int NUM_CATEGORIES = 12,
  parameter int MAX_ENTRIES    = 256
) (
  input logic clk,
  input logic rst,
  mcl_in_if.sink    in,
  mcl_out_if.source out
);
  localparam int EW = $clog2(MAX_ENTRIES);
  localparam int LW = $clog2(MAX_ENTRIES + 1);
  localparam int CW = (NUM_CATEGORIES > 1) ? $clog2(NUM_CATEGORIES) : 1;
  localparam int AW = CW + EW;
  localparam int DEPTH = NUM_CATEGORIES * MAX_ENTRIES;

  state_t state, state_next;
  logic [LW-1:0] lens [NUM_CATEGORIES];
  logic          act;
  logic [CW-1:0] cat;
  logic [31:0]   user, amt;
  logic [7:0]    pos_in;
  logic [LW-1:0] len;
  logic [LW-1:0] idx;
  logic [LW-1:0] idx_m1, idx_p1;
  logic [LW-1:0] cur_len;
  logic [31:0]   cur_key, cur_cnt;
  status_t       st;
  logic [31:0]   o_user, o_cnt;
  logic [8:0]    o_rank, o_len;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [63:0]   wdata, rdata;

  logic [32:0]   sum;
  logic [31:0]   sat_cnt;
  logic          bad_cat, pos_bad, key_hit, last_entry, move_up;

  mcl_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] c, input logic [LW-1:0] i);
    addr_of = AW'(c * MAX_ENTRIES) + AW'(i[EW-1:0]);
  endfunction

  assign sum = {1'b0, rdata[31:0]} + {1'b0, amt};
  assign sat_cnt = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  assign idx_m1 = idx - LW'(1);
  assign idx_p1 = idx + LW'(1);
  assign cur_len = lens[cat];
  assign bad_cat = {1'b0, in.category} >= 5'(NUM_CATEGORIES);
  assign pos_bad = 32'(pos_in) >= 32'(cur_len);
  assign key_hit = (rdata[63:32] == user);
  assign last_entry = (idx_p1 >= len);
  assign move_up = (rdata[31:0] < cur_cnt);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in.valid) begin
          state_next = bad_cat ? S_OUT : S_LEN;
        end
      end
      S_LEN: begin
        if (act == ACT_READ) begin
          state_next = pos_bad ? S_OUT : S_RD;
        end else if (cur_len == '0) begin
          state_next = S_UPDATE;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (key_hit) state_next = S_UPDATE;
        else if (last_entry) state_next = (len == LW'(MAX_ENTRIES)) ? S_OUT : S_UPDATE;
      end
      S_UPDATE: state_next = (idx == '0) ? S_OUT : S_BUB;
      S_BUB: state_next = move_up ? S_UPDATE : S_OUT;
      S_RD: state_next = S_OUT;
      S_OUT: if (out.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // The scan reads one entry ahead so that each entry costs one cycle.
  always_comb begin
    we = 1'b0;
    waddr = addr_of(cat, idx);
    wdata = {cur_key, cur_cnt};
    raddr = addr_of(cat, idx);
    case (state)
      S_LEN: if (act == ACT_READ) raddr = addr_of(cat, LW'(pos_in));
      S_SCAN: if (!last_entry) raddr = addr_of(cat, idx_p1);
      S_UPDATE: begin
        we = 1'b1;
        if (idx != '0) raddr = addr_of(cat, idx_m1);
      end
      S_BUB: begin
        // The upper neighbor moves down when its count is strictly smaller.
        if (move_up) begin
          we = 1'b1;
          wdata = rdata;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < NUM_CATEGORIES; i++) lens[i] <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (in.valid) begin
            act <= in.action;
            cat <= CW'(in.category);
            user <= in.user_id;
            amt <= in.amount;
            pos_in <= in.position;
            idx <= '0;
            st <= ST_BAD_CAT;
            o_user <= '0; o_cnt <= '0; o_rank <= '0; o_len <= '0;
          end
        end
        S_LEN: begin
          len <= cur_len;
          if (act == ACT_READ) begin
            o_len <= 9'(cur_len);
            st <= pos_bad ? ST_BAD_POS : ST_OK;
          end else if (cur_len == '0) begin
            cur_key <= user; cur_cnt <= amt;
            lens[cat] <= LW'(1);
            o_len <= 9'd1;
          end else begin
            o_len <= 9'(cur_len);
          end
        end
        S_SCAN: begin
          if (key_hit) begin
            cur_key <= user;
            cur_cnt <= sat_cnt;
          end else if (last_entry) begin
            if (len == LW'(MAX_ENTRIES)) begin
              st <= ST_FULL; o_user <= user;
            end else begin
              idx <= len; cur_key <= user; cur_cnt <= amt;
              lens[cat] <= len + LW'(1);
              o_len <= 9'(len + LW'(1));
            end
          end else begin
            idx <= idx_p1;
          end
        end
        S_UPDATE: begin
          st <= ST_OK;
          o_user <= cur_key;
          o_cnt <= cur_cnt;
          o_rank <= 9'(idx) + 9'd1;
        end
        S_BUB: begin
          if (move_up) idx <= idx_m1;
        end
        S_RD: begin
          o_user <= rdata[63:32];
          o_cnt <= rdata[31:0];
          o_rank <= 9'(pos_in) + 9'd1;
        end
        default: ;
      endcase
    end
  end

  assign in.ready = (state == S_IDLE);
  assign out.valid = (state == S_OUT);
  assign out.status = st;
  assign out.entry_user = o_user;
  assign out.entry_count = o_cnt;
  assign out.entry_rank = o_rank;
  assign out.list_length = o_len;

  ap_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in.ready |-> !out.valid) else $error("ready while result pending");
  ap_rank_ok: assert property (@(posedge clk) disable iff (rst)
    (out.valid && out.status == ST_OK) |-> (out.entry_rank != 9'd0 &&
     out.entry_rank <= out.list_length)) else $error("rank out of list");
  ap_hold: assert property (@(posedge clk) disable iff (rst)
    (out.valid && !out.ready) |=> out.valid) else $error("result dropped");
  ap_stable: assert property (@(posedge clk) disable iff (rst)
    (out.valid && !out.ready) |=> $stable({out.status, out.entry_user, out.entry_count,
     out.entry_rank, out.list_length})) else $error("result changed while stalled");
endmodule

/* tb/multi_category_leaderboard_core_tb.sv */
module multi_category_leaderboard_core_tb import mcl_pkg::*; ();

  localparam int NCAT = 12;
  localparam int MAXN = 256;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] entry_user;
    logic [31:0] entry_count;
    logic [8:0]  entry_rank;
    logic [8:0]  list_length;
  } board_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mcl_in_if  in_ch ();
  mcl_out_if out_ch ();

  multi_category_leaderboard_core u_dut (
    .clk (clk),
    .rst (rst),
    .in  (in_ch.sink),
    .out (out_ch.source)
  );

  // Shadow copy of every leaderboard, kept sorted the way the block keeps it.
  logic [31:0] shadow_keys [NCAT][MAXN];
  logic [31:0] shadow_counts [NCAT][MAXN];
  int unsigned shadow_len [NCAT];

  board_result_t pending_results [$];
  bit failed = 1'b0;
  bit idle_enable = 1'b1;
  int unsigned user_pool [8];

  initial forever #5 clk = ~clk;

  function automatic board_result_t predict_board(logic act, logic [3:0] cat, logic [31:0] uid,
                                                  logic [31:0] amt, logic [7:0] pos);
    board_result_t r;
    int unsigned len;
    int slot;
    bit found;
    logic [32:0] sum;
    logic [31:0] tk;
    logic [31:0] tc;
    r = '0;
    found = 1'b0;
    slot = 0;
    if (cat >= NCAT) begin
      r.status = ST_BAD_CAT;
      return r;
    end
    len = shadow_len[cat];
    r.list_length = len[8:0];
    if (act == ACT_READ) begin
      if (pos >= len) begin
        r.status = ST_BAD_POS;
      end else begin
        r.status = ST_OK;
        r.entry_user = shadow_keys[cat][pos];
        r.entry_count = shadow_counts[cat][pos];
        r.entry_rank = 9'(pos) + 9'd1;
      end
      return r;
    end
    for (int i = 0; i < len; i++) begin
      if (!found && shadow_keys[cat][i] == uid) begin
        found = 1'b1;
        slot = i;
      end
    end
    if (found) begin
      sum = {1'b0, shadow_counts[cat][slot]} + {1'b0, amt};
      shadow_counts[cat][slot] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    end else begin
      if (len >= MAXN) begin
        r.status = ST_FULL;
        r.entry_user = uid;
        return r;
      end
      slot = len;
      shadow_keys[cat][slot] = uid;
      shadow_counts[cat][slot] = amt;
      len++;
      shadow_len[cat] = len;
    end
    while (slot > 0 && shadow_counts[cat][slot-1] < shadow_counts[cat][slot]) begin
      tk = shadow_keys[cat][slot];
      tc = shadow_counts[cat][slot];
      shadow_keys[cat][slot] = shadow_keys[cat][slot-1];
      shadow_counts[cat][slot] = shadow_counts[cat][slot-1];
      shadow_keys[cat][slot-1] = tk;
      shadow_counts[cat][slot-1] = tc;
      slot--;
    end
    r.status = ST_OK;
    r.entry_user = shadow_keys[cat][slot];
    r.entry_count = shadow_counts[cat][slot];
    r.entry_rank = 9'(slot + 1);
    r.list_length = len[8:0];
    return r;
  endfunction

  task automatic send_request(logic act, logic [3:0] cat, logic [31:0] uid, logic [31:0] amt,
                              logic [7:0] pos);
    board_result_t exp_r;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.category <= cat;
    in_ch.user_id <= uid;
    in_ch.amount <= amt;
    in_ch.position <= pos;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    exp_r = predict_board(act, cat, uid, amt, pos);
    pending_results = {pending_results, exp_r};
    @(negedge clk);
  endtask

  // Receiver side: random stall bursts, then result checking at the rising edge.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    board_result_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected");
        failed = 1'b1;
      end else begin
        e = pending_results.pop_front();
        if (out_ch.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_ch.status);
          failed = 1'b1;
        end
        if (out_ch.entry_user !== e.entry_user) begin
          $error("entry_user exp %0h got %0h", e.entry_user, out_ch.entry_user);
          failed = 1'b1;
        end
        if (out_ch.entry_count !== e.entry_count) begin
          $error("entry_count exp %0h got %0h", e.entry_count, out_ch.entry_count);
          failed = 1'b1;
        end
        if (out_ch.entry_rank !== e.entry_rank) begin
          $error("entry_rank exp %0d got %0d", e.entry_rank, out_ch.entry_rank);
          failed = 1'b1;
        end
        if (out_ch.list_length !== e.list_length) begin
          $error("list_length exp %0d got %0d", e.list_length, out_ch.list_length);
          failed = 1'b1;
        end
      end
    end
  end

  task automatic test_directed();
    send_request(ACT_READ, 4'd0, 32'h0, 32'h0, 8'd0);
    send_request(ACT_ADD, 4'd12, 32'h1, 32'h1, 8'd0);
    send_request(ACT_READ, 4'd15, 32'h0, 32'h0, 8'd255);
    send_request(ACT_ADD, 4'd0, 32'hFFFF_FFFF, 32'h0, 8'hFF);
    send_request(ACT_ADD, 4'd0, 32'h0, 32'h5, 8'h0);
    send_request(ACT_ADD, 4'd0, 32'h1234, 32'h5, 8'h0);
    send_request(ACT_ADD, 4'd0, 32'hFFFF_FFFF, 32'h6, 8'h0);
    send_request(ACT_ADD, 4'd0, 32'h0, 32'hFFFF_FFFF, 8'h0);
    send_request(ACT_ADD, 4'd0, 32'h1234, 32'hFFFF_FFFF, 8'h0);
    send_request(ACT_READ, 4'd0, 32'h0, 32'h0, 8'd0);
    send_request(ACT_READ, 4'd0, 32'h0, 32'h0, 8'd1);
    send_request(ACT_READ, 4'd0, 32'h0, 32'h0, 8'd2);
    send_request(ACT_READ, 4'd0, 32'h0, 32'h0, 8'd3);
    send_request(ACT_ADD, 4'd11, 32'hA5A5_5A5A, 32'h8000_0000, 8'h0);
    send_request(ACT_READ, 4'd11, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0);
  endtask

  // Fills one category to capacity, then tries a new user, adds to an existing one and reads the far end.
  task automatic test_full_table();
    for (int i = 0; i < MAXN; i++)
      send_request(ACT_ADD, 4'd5, 32'h5000_0000 + i, $urandom_range(0, 20), 8'h0);
    send_request(ACT_ADD, 4'd5, 32'hDEAD_BEEF, 32'h1, 8'h0);
    send_request(ACT_ADD, 4'd5, 32'h5000_0007, 32'h3, 8'h0);
    send_request(ACT_READ, 4'd5, 32'h0, 32'h0, 8'd255);
  endtask

  task automatic test_random(int n);
    logic act;
    logic [3:0] cat;
    logic [31:0] uid;
    logic [31:0] amt;
    logic [7:0] pos;
    for (int i = 0; i < n; i++) begin
      act = ($urandom_range(0, 3) == 0);
      cat = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(12, 15))
                                         : 4'($urandom_range(0, 11));
      uid = ($urandom_range(0, 3) == 0) ? $urandom : user_pool[$urandom_range(0, 7)];
      case ($urandom_range(0, 3))
        0: amt = $urandom;
        1: amt = 32'hFFFF_FFFF - $urandom_range(0, 3);
        default: amt = $urandom_range(0, 100);
      endcase
      pos = ($urandom_range(0, 1) && cat < NCAT && shadow_len[cat] > 0) ?
            8'($urandom_range(0, shadow_len[cat] - 1)) : 8'($urandom_range(0, 255));
      send_request(act, cat, uid, amt, pos);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = ACT_ADD;
    in_ch.category = '0;
    in_ch.user_id = '0;
    in_ch.amount = '0;
    in_ch.position = '0;
    for (int c = 0; c < NCAT; c++) shadow_len[c] = 0;
    for (int k = 0; k < 8; k++) user_pool[k] = $urandom;
    user_pool[0] = 32'h0;
    user_pool[1] = 32'hFFFF_FFFF;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_full_table();
    test_random(700);
    idle_enable = 1'b0;
    test_random(200);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (!failed && pending_results.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #60_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

/* files.f */
rtl/core/mcl_pkg.sv
rtl/core/mcl_if.sv
rtl/core/mcl_ram.sv
rtl/core/multi_category_leaderboard_core.sv
tb/multi_category_leaderboard_core_tb.sv
